// ===== design/srw_pkg.sv =====
`default_nettype none
package srw_pkg;

  localparam int unsigned SeqInW = 16;
  localparam int unsigned ExtW   = 32;

  typedef logic [SeqInW-1:0] seq_in_t;

endpackage
`default_nettype wire

// ===== design/srw_if.sv =====
`default_nettype none
interface srw_seq_if
  import srw_pkg::*;
();
  logic    valid;
  logic    ready;
  seq_in_t seq_number;

  modport source (output valid, output seq_number, input ready);
  modport sink   (input valid, input seq_number, output ready);
endinterface

interface srw_result_if
  import srw_pkg::*;
();
  logic valid;
  logic ready;
  logic accepted;

  modport source (output valid, output accepted, input ready);
  modport sink   (input valid, input accepted, output ready);
endinterface
`default_nettype wire

// ===== design/sequence_receive_window.sv =====
// steps: accept, check, then an optional jump and up to about WINDOW_BITS single-place
// advances of the expected number, one place per cycle, then the result word is loaded
// once the output is free; a stale number goes from the check straight to the result
// throughput: one word at a time; the input is not ready until the result is loaded
// reset: asynchronous, clears the expected number, the received map and the control state
`default_nettype none
module sequence_receive_window
  import srw_pkg::*;
#(
  parameter int unsigned WINDOW_BITS = 32,
  parameter int unsigned SEQ_BITS    = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  srw_seq_if.sink     in_i,
  srw_result_if.source out_o
);

  localparam int unsigned IdxW = $clog2(WINDOW_BITS);

  localparam logic [SEQ_BITS-1:0] WinSeq    = SEQ_BITS'(WINDOW_BITS);
  localparam logic [SEQ_BITS-1:0] WinM1Seq  = SEQ_BITS'(WINDOW_BITS - 1);
  localparam logic [SEQ_BITS-1:0] TwoWinSeq = SEQ_BITS'(2 * WINDOW_BITS);
  localparam logic [SEQ_BITS-1:0] OneSeq    = SEQ_BITS'(1);
  localparam logic [SEQ_BITS-1:0] ZeroSeq   = '0;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_JUMP   = 3'd2;
  localparam logic [2:0] S_SLIDE  = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_ADV    = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]             state_q, state_d;
  logic [SEQ_BITS-1:0]    exp_q, exp_d;
  logic [WINDOW_BITS-1:0] map_q, map_d;
  logic [SEQ_BITS-1:0]    seq_q, seq_d;
  logic [SEQ_BITS-1:0]    off_q, off_d;
  logic                   acc_q, acc_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_acc_q, out_acc_d;

  logic [ExtW-1:0]        seq_ext;
  logic [SEQ_BITS-1:0]    diff;
  logic [SEQ_BITS-1:0]    off_now;
  logic [SEQ_BITS-1:0]    jump;
  logic [IdxW-1:0]        off_idx;
  logic                   stale;
  logic                   out_free;

  assign seq_ext  = ExtW'(in_i.seq_number);
  assign diff     = exp_q - seq_q;
  assign off_now  = seq_q - exp_q;
  assign jump     = off_q - WinM1Seq;
  assign off_idx  = off_q[IdxW-1:0];
  assign stale    = (seq_q < exp_q) && (diff <= TwoWinSeq);
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready     = (state_q == S_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.accepted = out_acc_q;

  always_comb begin
    state_d     = state_q;
    exp_d       = exp_q;
    map_d       = map_q;
    seq_d       = seq_q;
    off_d       = off_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    out_acc_d   = out_acc_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          seq_d   = seq_ext[SEQ_BITS-1:0];
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        off_d = off_now;
        if (stale) begin
          acc_d   = 1'b0;
          state_d = S_FINISH;
        end else if (off_now >= WinSeq) begin
          state_d = S_JUMP;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_JUMP: begin
        // window jumps so the incoming number lands on the last map position
        if (jump >= WinSeq) begin
          map_d = '0;
        end else begin
          map_d = map_q >> jump;
        end
        exp_d   = exp_q + jump;
        off_d   = WinM1Seq;
        state_d = S_SLIDE;
      end
      S_SLIDE: begin
        if ((off_q != ZeroSeq) && map_q[0]) begin
          exp_d = exp_q + OneSeq;
          map_d = map_q >> 1;
          off_d = off_q - OneSeq;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (off_q == ZeroSeq) begin
          if (!map_q[0]) begin
            exp_d   = exp_q + OneSeq;
            map_d   = map_q >> 1;
            acc_d   = 1'b1;
            state_d = S_ADV;
          end else begin
            // already marked when the slide reached it
            acc_d   = 1'b0;
            state_d = S_FINISH;
          end
        end else begin
          if (!map_q[off_idx]) begin
            map_d[off_idx] = 1'b1;
            acc_d          = 1'b1;
          end else begin
            acc_d = 1'b0;
          end
          state_d = S_FINISH;
        end
      end
      S_ADV: begin
        // skip past contiguously received entries
        if (map_q[0]) begin
          exp_d = exp_q + OneSeq;
          map_d = map_q >> 1;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_acc_d   = acc_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      exp_q       <= '0;
      map_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      exp_q       <= exp_d;
      map_q       <= map_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q     <= seq_d;
    off_q     <= off_d;
    acc_q     <= acc_d;
    out_acc_q <= out_acc_d;
  end

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
module tb;
  import srw_pkg::*;

  localparam int unsigned Win       = 32;
  localparam int unsigned NumRandom = 1400;
  localparam int unsigned HoldLen   = 250;
  localparam int unsigned TailLen   = 2 * Win + 10;
  localparam int unsigned IdleLimit = 3000;

  typedef struct packed {
    seq_in_t seq;
    logic    ok;
  } verdict_t;

  logic clk;
  logic rst_n;

  srw_seq_if    seq_if ();
  srw_result_if res_if ();

  sequence_receive_window dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (seq_if),
    .out_o  (res_if)
  );

  seq_in_t     seq_pending[$];
  verdict_t    verdict_q[$];

  // checker-side window state, stepped on every accepted word
  seq_in_t     rx_next;
  logic [31:0] rx_seen;
  // generator-side copy, so stimulus can aim at the live window
  seq_in_t     gen_next;
  logic [31:0] gen_seen;

  int unsigned n_items;
  int unsigned n_taken;
  int unsigned errors;
  int unsigned idle_cycles;
  int unsigned in_gap;
  int unsigned out_stall;
  int unsigned hold_left;
  int unsigned hold_at;
  logic        in_taken;
  logic        calm;

  assign calm = ((n_taken / 200) % 4) == 2;

  // one step of the receive window: returns 1 when the number is new
  function automatic logic window_step(inout seq_in_t nxt, inout logic [31:0] seen,
                                       input seq_in_t seq);
    seq_in_t off;
    seq_in_t jump;
    logic    ok;
    ok = 1'b0;
    if (seq < nxt && seq_in_t'(nxt - seq) <= seq_in_t'(2 * Win)) begin
      ok = 1'b0;
    end else begin
      off = seq - nxt;
      if (off >= seq_in_t'(Win)) begin
        jump = off - seq_in_t'(Win - 1);
        if (jump >= seq_in_t'(Win)) seen = '0;
        else seen = seen >> jump;
        nxt = nxt + jump;
        off = seq_in_t'(Win - 1);
        while (off > 0 && seen[0]) begin
          nxt  = nxt + 1'b1;
          seen = seen >> 1;
          off  = off - 1'b1;
        end
      end
      if (off == 0) begin
        if (!seen[0]) begin
          do begin
            nxt  = nxt + 1'b1;
            seen = seen >> 1;
          end while (seen[0]);
          ok = 1'b1;
        end
      end else if (!seen[off]) begin
        seen[off] = 1'b1;
        ok        = 1'b1;
      end
    end
    return ok;
  endfunction

  function automatic int unsigned draw_gap(input logic quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_item(input seq_in_t seq);
    seq_pending = {seq_pending, seq};
    void'(window_step(gen_next, gen_seen, seq));
    n_items = n_items + 1;
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors = errors + 1;
  endtask

  // mark a shuffled run of numbers ahead of the expected one, then close or slide it
  task automatic add_fill();
    int unsigned k;
    int unsigned j;
    int unsigned t;
    int unsigned tmp;
    int unsigned offs[31];
    seq_in_t     base;
    base = gen_next;
    k = $urandom_range(1, 31);
    for (j = 0; j < k; j++) offs[j] = j + 1;
    for (j = k - 1; j > 0; j--) begin
      t       = $urandom_range(0, j);
      tmp     = offs[j];
      offs[j] = offs[t];
      offs[t] = tmp;
    end
    for (j = 0; j < k; j++) add_item(base + seq_in_t'(offs[j]));
    if ($urandom_range(0, 1)) add_item(base);
    else add_item(base + seq_in_t'(Win + $urandom_range(0, k)));
  endtask

  task automatic build_stimulus();
    int unsigned r;
    int unsigned j;
    int unsigned len;
    seq_in_t     last;
    // directed part
    add_item(16'd0);
    add_item(16'd0);
    add_item(16'd5);
    add_item(16'd5);
    add_item(16'd3);
    add_item(16'd2);
    add_item(16'd1);
    add_item(gen_next + seq_in_t'(Win - 1));
    add_item(gen_next + seq_in_t'(Win));
    add_item(gen_next + 16'd1);
    add_item(gen_next + 16'd2);
    add_item(gen_next + 16'd3);
    add_item(gen_next + seq_in_t'(Win + 2));
    add_item(16'hFFFF);
    add_item(16'h0005);
    add_item(gen_next - seq_in_t'(2 * Win));
    add_item(gen_next - seq_in_t'(2 * Win + 1));
    add_item(gen_next);
    add_item(gen_next);
    add_item(gen_next + 16'd100);
    add_item(16'h0000);
    add_item(16'hAAAA);
    add_item(16'h5555);
    last = 16'h5555;
    // random part
    while (n_items < NumRandom + 23) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        last = gen_next + seq_in_t'($urandom_range(0, 40));
        add_item(last);
      end else if (r < 50) begin
        last = gen_next - seq_in_t'($urandom_range(1, 70));
        add_item(last);
      end else if (r < 58) begin
        add_item(last);
      end else if (r < 75) begin
        add_fill();
      end else if (r < 90) begin
        len = $urandom_range(2, 10);
        for (j = 0; j < len; j++) begin
          last = gen_next + seq_in_t'($urandom_range(0, 2));
          add_item(last);
        end
      end else begin
        last = seq_in_t'($urandom);
        add_item(last);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n              = 1'b0;
    seq_if.valid       = 1'b0;
    seq_if.seq_number  = '0;
    res_if.ready       = 1'b0;
    rx_next            = '0;
    rx_seen            = '0;
    gen_next           = '0;
    gen_seen           = '0;
    n_items            = 0;
    n_taken            = 0;
    errors             = 0;
    in_gap             = 0;
    out_stall          = 0;
    hold_left          = 0;
    hold_at            = 100;
    in_taken           = 1'b0;
    build_stimulus();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    // checked at the rising edge, once the sender has settled for the cycle
    do @(posedge clk);
    while (seq_pending.size() != 0 || seq_if.valid || verdict_q.size() != 0);
    repeat (TailLen) @(negedge clk);
    if (verdict_q.size() != 0) report_mismatch("results still outstanding at end of run");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // sender: holds the word until taken, then waits out its gap
  always @(negedge clk) begin
    if (rst_n) begin
      if (!seq_if.valid || in_taken) begin
        if (in_gap > 0) begin
          seq_if.valid <= 1'b0;
          in_gap       <= in_gap - 1;
        end else if (seq_pending.size() != 0) begin
          seq_if.valid      <= 1'b1;
          seq_if.seq_number <= seq_pending[0];
          seq_pending.delete(0);
          in_gap            <= draw_gap(calm);
        end else begin
          seq_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus a long hold-off now and then so the input backs up
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (n_taken >= hold_at) begin
        res_if.ready <= 1'b0;
        hold_left    <= HoldLen;
        hold_at      <= hold_at + 800;
      end else if (out_stall > 0) begin
        res_if.ready <= 1'b0;
        out_stall    <= out_stall - 1;
      end else begin
        out_stall    <= draw_gap(calm);
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    verdict_t got;
    in_taken <= seq_if.valid && seq_if.ready;
    if (rst_n && seq_if.valid && seq_if.ready) begin
      got.seq   = seq_if.seq_number;
      got.ok    = window_step(rx_next, rx_seen, seq_if.seq_number);
      verdict_q = {verdict_q, got};
      n_taken <= n_taken + 1;
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("result word %0b with nothing outstanding",
                                  res_if.accepted));
      end else begin
        want = verdict_q[0];
        verdict_q.delete(0);
        if (res_if.accepted !== want.ok)
          report_mismatch($sformatf("seq %h: accepted %b, want %b", want.seq,
                                    res_if.accepted, want.ok));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((seq_if.valid && seq_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== filelist.f =====
design/srw_pkg.sv
design/srw_if.sv
design/sequence_receive_window.sv
dv/tb.sv
